// ===== sv/bpa_pkg.sv =====
// bpa_pkg: shared widths, codes and types for the bitmap page allocator.
// No dependencies.
`default_nettype none
package bpa_pkg;

  localparam int NUM_BLOCKS_DEF = 64;
  localparam int MAX_JOBS_DEF   = 16;

  // field widths fixed by the interface
  localparam int FUNC_W = 2;
  localparam int JOB_W  = 4;
  localparam int CNT_W  = 7;
  localparam int IDX_W  = 6;
  localparam int ST_W   = 2;
  localparam int OWN_W  = 5;

  // owner tag for reserved blocks, matches no job id
  localparam logic [OWN_W-1:0] NO_OWNER = 5'd31;

  localparam logic [FUNC_W-1:0] FN_RESERVE = 2'd0;
  localparam logic [FUNC_W-1:0] FN_ALLOC   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_RELEASE = 2'd2;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_ACTIVE  = 2'd1;
  localparam logic [ST_W-1:0] ST_NOSPACE = 2'd2;
  localparam logic [ST_W-1:0] ST_NOJOB   = 2'd3;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // scan token walking down the cell chain
  typedef struct packed {
    logic             valid;
    logic             op;
    logic [JOB_W-1:0] job;
    logic [CNT_W-1:0] remaining;
  } token_t;

  // per-cell events seen by the controller
  typedef struct packed {
    logic live;
    logic grant;
    logic last;
    logic freed;
    logic took;
  } cell_evt_t;

endpackage
`default_nettype wire

// ===== sv/bpa_cell.sv =====
// bpa_cell: one block of the bitmap (used bit, owner) plus one token stage.
// Depends on bpa_pkg.
`default_nettype none
module bpa_cell #(
  parameter int INDEX = 0
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    adv,
  input  wire bpa_pkg::token_t         tok_in,
  output bpa_pkg::token_t              tok_out,
  input  wire logic                    rsv_en,
  input  wire logic [bpa_pkg::IDX_W-1:0] rsv_idx,
  output bpa_pkg::cell_evt_t           evt
);
  import bpa_pkg::*;

  token_t           tok_q;
  logic             used;
  logic [OWN_W-1:0] owner;

  logic alloc_hit;
  logic rel_hit;
  logic rsv_hit;
  logic is_last;

  assign alloc_hit = tok_q.valid && (tok_q.op == OP_ALLOC) && !used;
  assign rel_hit   = tok_q.valid && (tok_q.op == OP_RELEASE) && used &&
                     (owner == {1'b0, tok_q.job});
  assign rsv_hit   = rsv_en && (rsv_idx == IDX_W'(INDEX)) && !used;
  assign is_last   = (tok_q.remaining == CNT_W'(1));

  always_comb begin
    tok_out = tok_q;
    if (alloc_hit) begin
      tok_out.remaining = tok_q.remaining - CNT_W'(1);
      // token retires once the request is filled
      if (is_last) begin
        tok_out.valid = 1'b0;
      end
    end
  end

  assign evt.live  = tok_q.valid;
  assign evt.grant = alloc_hit;
  assign evt.last  = alloc_hit && is_last;
  assign evt.freed = rel_hit;
  assign evt.took  = rsv_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_q.valid <= 1'b0;
      used        <= 1'b0;
    end else begin
      if (adv) begin
        tok_q <= tok_in;
        if (alloc_hit) begin
          used  <= 1'b1;
          owner <= {1'b0, tok_q.job};
        end
        if (rel_hit) begin
          used <= 1'b0;
        end
      end
      if (rsv_hit) begin
        used  <= 1'b1;
        owner <= NO_OWNER;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/bitmap_page_allocator.sv =====
// Bitmap first-fit page allocator: top level, job table and output stage.
// Depends on bpa_pkg and bpa_cell.
// Reserve, rejected requests and zero-block allocate answer from the output register;
// each grant of an allocate follows as its token meets a free block, and a release
// answers once its token leaves the last cell. One item at a time: no request is taken
// while a token walks the chain, one cell per cycle unless the output stalls.
// Reset: synchronous, clears bitmap, job table and used count at once.
`default_nettype none
module bitmap_page_allocator #(
  parameter int NUM_BLOCKS = bpa_pkg::NUM_BLOCKS_DEF,
  parameter int MAX_JOBS   = bpa_pkg::MAX_JOBS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [bpa_pkg::FUNC_W-1:0]   func,
  input  wire logic [bpa_pkg::JOB_W-1:0]    job_id,
  input  wire logic [bpa_pkg::CNT_W-1:0]    block_count,
  input  wire logic [bpa_pkg::IDX_W-1:0]    block_index,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [bpa_pkg::IDX_W-1:0]         granted_block,
  output logic [bpa_pkg::ST_W-1:0]          status,
  output logic                              block_valid,
  output logic                              last
);
  import bpa_pkg::*;

  // used count holds 0..NUM_BLOCKS; compares run one bit wider than any operand
  localparam int UC_W  = $clog2(NUM_BLOCKS + 1);
  localparam int CMP_W = ((UC_W > CNT_W) ? UC_W : CNT_W) + 1;
  localparam int JA_W  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;

  // token chain: tok[0] is injected here, tok[NUM_BLOCKS] falls off the end
  token_t    tok [NUM_BLOCKS+1];
  cell_evt_t evt [NUM_BLOCKS];

  logic [MAX_JOBS-1:0] job_active;
  logic [UC_W-1:0]     used_count;

  logic              adv;        // chain and output stage may move
  logic              accept;
  logic              any_live, any_grant, grant_last, any_freed, any_took;
  logic [IDX_W-1:0]  grant_idx;
  logic              job_ok;     // job id inside the job table
  logic [JA_W-1:0]   job_sel;
  logic              job_on;
  logic              no_space;
  logic [CMP_W-1:0]  free_count;
  logic              rsv_en;
  logic              tail_rel;   // release token leaving the last cell

  assign adv      = !out_valid || out_ready;
  assign in_ready = !any_live && adv;
  assign accept   = in_valid && in_ready;

  assign job_ok     = (CMP_W'(job_id) < CMP_W'(MAX_JOBS));
  assign job_sel    = JA_W'(job_id);
  assign job_on     = job_ok && job_active[job_sel];
  assign free_count = CMP_W'(NUM_BLOCKS) - CMP_W'(used_count);
  assign no_space   = (CMP_W'(block_count) > free_count);
  assign rsv_en     = accept && (func == FN_RESERVE);
  assign tail_rel   = tok[NUM_BLOCKS].valid && (tok[NUM_BLOCKS].op == OP_RELEASE);

  // token handed to the first cell on an accepted allocate or release
  always_comb begin
    tok[0].valid     = 1'b0;
    tok[0].op        = OP_ALLOC;
    tok[0].job       = job_id;
    tok[0].remaining = block_count;
    if (accept) begin
      unique case (func)
        FN_ALLOC: begin
          tok[0].valid = job_ok && !job_active[job_sel] && !no_space &&
                         (block_count != '0);
        end
        FN_RELEASE: begin
          tok[0].valid = job_on;
          tok[0].op    = OP_RELEASE;
        end
        default: begin
          tok[0].valid = 1'b0;
        end
      endcase
    end
  end

  for (genvar k = 0; k < NUM_BLOCKS; k++) begin : g_cell
    bpa_cell #(
      .INDEX (k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .tok_in  (tok[k]),
      .tok_out (tok[k+1]),
      .rsv_en  (rsv_en),
      .rsv_idx (block_index),
      .evt     (evt[k])
    );
  end

  // at most one cell holds the token, so plain ORs collect its events
  always_comb begin
    any_live   = 1'b0;
    any_grant  = 1'b0;
    grant_last = 1'b0;
    any_freed  = 1'b0;
    any_took   = 1'b0;
    grant_idx  = '0;
    for (int k = 0; k < NUM_BLOCKS; k++) begin
      any_live   = any_live   | evt[k].live;
      any_grant  = any_grant  | evt[k].grant;
      grant_last = grant_last | evt[k].last;
      any_freed  = any_freed  | evt[k].freed;
      any_took   = any_took   | evt[k].took;
      if (evt[k].grant) begin
        grant_idx = grant_idx | IDX_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      job_active <= '0;
      used_count <= '0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end

      // used count: one event per cycle at most
      if (any_took) begin
        used_count <= used_count + UC_W'(1);
      end else if (adv && any_grant) begin
        used_count <= used_count + UC_W'(1);
      end else if (adv && any_freed) begin
        used_count <= used_count - UC_W'(1);
      end

      if (accept) begin
        granted_block <= '0;
        block_valid   <= 1'b0;
        last          <= 1'b1;
        status        <= ST_OK;
        unique case (func)
          FN_RESERVE: begin
            out_valid <= 1'b1;
          end
          FN_ALLOC: begin
            if (!job_ok) begin
              status    <= ST_NOJOB;
              out_valid <= 1'b1;
            end else if (job_active[job_sel]) begin
              status    <= ST_ACTIVE;
              out_valid <= 1'b1;
            end else if (no_space) begin
              status    <= ST_NOSPACE;
              out_valid <= 1'b1;
            end else begin
              job_active[job_sel] <= 1'b1;
              // zero-block request answers at once; otherwise grants follow
              out_valid <= (block_count == '0);
            end
          end
          FN_RELEASE: begin
            if (job_on) begin
              job_active[job_sel] <= 1'b0;
            end else begin
              status    <= ST_NOJOB;
              out_valid <= 1'b1;
            end
          end
          default: begin
            // unused code: no transaction on the output
          end
        endcase
      end else if (adv && any_grant) begin
        granted_block <= grant_idx;
        block_valid   <= 1'b1;
        last          <= grant_last;
        status        <= ST_OK;
        out_valid     <= 1'b1;
      end else if (adv && tail_rel) begin
        granted_block <= '0;
        block_valid   <= 1'b0;
        last          <= 1'b1;
        status        <= ST_OK;
        out_valid     <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire
